// ----- hdl/polyphonic_voice_allocator_macros.svh -----
// Assertion macros shared by the voice allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PVA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PVA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/pva_pkg.sv -----
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; imported by pva_voice_ram and the top level.
package pva_pkg;

   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_ALL_OFF  = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   localparam logic ACT_TRIGGER = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 8;
   localparam int TIME_W  = 32;
   localparam int PITCH_W = 14;
   localparam int LEVEL_W = 8;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

   // One voice entry in the table: note held and tick at which it started.
   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [TIME_W-1:0] start;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_FLUSH   = 5'b00100,
      ST_ALL_OFF = 5'b01000,
      ST_TRIGGER = 5'b10000
   } state_type;

endpackage

// ----- hdl/pva_voice_ram.sv -----
// Voice table memory: one write port, one read port, registered read data.
// Depends on pva_pkg (entry_type).
module pva_voice_ram #(
   parameter int DEPTH  = 6,
   parameter int ADDR_W = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pva_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pva_pkg::entry_type  rd_data
);
   import pva_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/polyphonic_voice_allocator.sv -----
// Polyphonic voice allocator with oldest-note stealing; top level.
// Depends on pva_pkg, pva_voice_ram and polyphonic_voice_allocator_macros.svh.
//
// Commands enter on start while busy is low. A tick only advances the 32-bit
// wrapping time counter and is taken at once, so ticks may arrive every cycle.
// Note-on and note-off walk the voice table (note and start time of each
// voice, held in a one-port-read RAM) one entry per cycle, issuing a read
// per entry and examining each entry when its registered read data
// returns. Busy stays high through the walk and while a note-off emits
// its final release (when any voice matched) or a note-on emits its
// trigger. All-notes-off emits one release per voice, one a cycle, with
// busy held high until the last release. Results leave through
// registered ports: each shows for exactly one cycle with rsp_strobe high
// and cannot be held off, so the receiver must take every strobed item.
// Results of one command come in ascending voice order, rsp_last marks the
// final one, and a note-off that matches nothing produces no item at all.
// The table is written only after a walk has finished and before the next
// command is taken, so reads and writes to one entry never overlap.
`include "polyphonic_voice_allocator_macros.svh"

module polyphonic_voice_allocator #(
   parameter int NUM_VOICES = 6
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [1:0]                               req_command,
   input  logic [pva_pkg::NOTE_W-1:0]               req_note,
   input  logic [pva_pkg::VEL_W-1:0]                req_velocity,
   output logic                                     rsp_strobe,
   output logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] rsp_voice_index,
   output logic                                     rsp_action,
   output logic [pva_pkg::PITCH_W-1:0]              rsp_pitch,
   output logic [pva_pkg::LEVEL_W-1:0]              rsp_level,
   output logic                                     rsp_last
);
   import pva_pkg::*;

   localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CNT_W = $clog2(NUM_VOICES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_VOICES);

   // Command and control registers
   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [NOTE_W-1:0]     note_ff, note_in;
   logic [VEL_W-1:0]      vel_ff, vel_in;
   logic [TIME_W-1:0]     tick_ff, tick_in;
   logic [NUM_VOICES-1:0] busy_ff, busy_in;

   // Table walk: read issue counter and the entry whose data is returning
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]      proc_idx_ff, proc_idx_in;

   // Note-on selection candidates
   logic                  match_found_ff, match_found_in;
   logic [IDX_W-1:0]      match_idx_ff, match_idx_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]     best_age_ff, best_age_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;

   // Note-off: one matched voice held back until we know whether it is last
   logic                  pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;

   logic [IDX_W-1:0]      all_idx_ff, all_idx_in;

   // Result registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [IDX_W-1:0]      rsp_voice_index_ff, rsp_voice_index_in;
   logic                  rsp_action_ff, rsp_action_in;
   logic [PITCH_W-1:0]    rsp_pitch_ff, rsp_pitch_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memory ports
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   entry_type             rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   logic                  accept;
   logic                  hit;
   logic [TIME_W-1:0]     age;
   logic [IDX_W-1:0]      sel_idx;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   pva_voice_ram #(
      .DEPTH  (NUM_VOICES),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entry returning from the RAM: a matching busy voice, and its age.
   // Age counts modulo 2^32, which keeps the order right across a wrap.
   assign hit = proc_vld_ff && busy_ff[proc_idx_ff] && (rd_data.note == note_ff);
   assign age = tick_ff - rd_data.start;

   // Note-on priority: voice already on this note, then lowest free, then oldest.
   assign sel_idx = match_found_ff ? match_idx_ff :
                    free_found_ff  ? free_idx_ff  : best_idx_ff;

   always_comb begin
      state_in           = state_ff;
      cmd_in             = cmd_ff;
      note_in            = note_ff;
      vel_in             = vel_ff;
      tick_in            = tick_ff;
      busy_in            = busy_ff;
      rd_cnt_in          = rd_cnt_ff;
      proc_vld_in        = 1'b0;
      proc_idx_in        = proc_idx_ff;
      match_found_in     = match_found_ff;
      match_idx_in       = match_idx_ff;
      free_found_in      = free_found_ff;
      free_idx_in        = free_idx_ff;
      best_age_in        = best_age_ff;
      best_idx_in        = best_idx_ff;
      pend_vld_in        = pend_vld_ff;
      pend_idx_in        = pend_idx_ff;
      all_idx_in         = all_idx_ff;
      rsp_strobe_in      = 1'b0;
      rsp_voice_index_in = rsp_voice_index_ff;
      rsp_action_in      = rsp_action_ff;
      rsp_pitch_in       = rsp_pitch_ff;
      rsp_level_in       = rsp_level_ff;
      rsp_last_in        = rsp_last_ff;
      rd_en              = 1'b0;
      rd_addr            = rd_cnt_ff[IDX_W-1:0];
      wr_en              = 1'b0;
      wr_addr            = sel_idx;
      wr_data.note       = note_ff;
      wr_data.start      = tick_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = cmd_type'(req_command);
               note_in = req_note;
               vel_in  = req_velocity;
               case (cmd_type'(req_command))
                  CMD_TICK: begin
                     tick_in = tick_ff + TIME_W'(1);
                  end
                  CMD_ALL_OFF: begin
                     all_idx_in = '0;
                     state_in   = ST_ALL_OFF;
                  end
                  CMD_NOTE_ON, CMD_NOTE_OFF: begin
                     rd_cnt_in      = '0;
                     match_found_in = 1'b0;
                     free_found_in  = 1'b0;
                     pend_vld_in    = 1'b0;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one read a cycle until every entry has been requested
            if (rd_cnt_ff < CNT_END) begin
               rd_en       = 1'b1;
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               proc_vld_in = 1'b1;
               proc_idx_in = rd_cnt_ff[IDX_W-1:0];
            end
            // Examine the entry read in the previous cycle
            if (proc_vld_ff) begin
               if (cmd_ff == CMD_NOTE_OFF) begin
                  if (hit) begin
                     // Emit the previously held match; it is not the last one
                     if (pend_vld_ff) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_voice_index_in = pend_idx_ff;
                        rsp_action_in      = ACT_RELEASE;
                        rsp_pitch_in       = '0;
                        rsp_level_in       = '0;
                        rsp_last_in        = 1'b0;
                     end
                     pend_vld_in          = 1'b1;
                     pend_idx_in          = proc_idx_ff;
                     busy_in[proc_idx_ff] = 1'b0;
                  end
                  if (proc_idx_ff == LAST_IDX) begin
                     state_in = (pend_vld_ff || hit) ? ST_FLUSH : ST_IDLE;
                  end
               end else begin
                  if (hit && !match_found_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = proc_idx_ff;
                  end
                  if (!busy_ff[proc_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = proc_idx_ff;
                  end
                  // Strictly older wins, so ties keep the lower voice
                  if ((proc_idx_ff == '0) || (age > best_age_ff)) begin
                     best_age_in = age;
                     best_idx_in = proc_idx_ff;
                  end
                  if (proc_idx_ff == LAST_IDX) begin
                     state_in = ST_TRIGGER;
                  end
               end
            end
         end

         ST_FLUSH: begin
            rsp_strobe_in      = 1'b1;
            rsp_voice_index_in = pend_idx_ff;
            rsp_action_in      = ACT_RELEASE;
            rsp_pitch_in       = '0;
            rsp_level_in       = '0;
            rsp_last_in        = 1'b1;
            pend_vld_in        = 1'b0;
            state_in           = ST_IDLE;
         end

         ST_ALL_OFF: begin
            rsp_strobe_in       = 1'b1;
            rsp_voice_index_in  = all_idx_ff;
            rsp_action_in       = ACT_RELEASE;
            rsp_pitch_in        = '0;
            rsp_level_in        = '0;
            rsp_last_in         = (all_idx_ff == LAST_IDX);
            busy_in[all_idx_ff] = 1'b0;
            if (all_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               all_idx_in = all_idx_ff + IDX_W'(1);
            end
         end

         ST_TRIGGER: begin
            // Write back note and start time, mark the voice busy
            wr_en              = 1'b1;
            busy_in[sel_idx]   = 1'b1;
            rsp_strobe_in      = 1'b1;
            rsp_voice_index_in = sel_idx;
            rsp_action_in      = ACT_TRIGGER;
            rsp_pitch_in       = {note_ff, 7'b0};
            rsp_level_in       = vel_ff[VEL_W-1] ? LEVEL_MAX : {vel_ff[VEL_W-2:0], 1'b0};
            rsp_last_in        = 1'b1;
            state_in           = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         busy_ff       <= '0;
         rd_cnt_ff     <= '0;
         proc_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         busy_ff       <= busy_in;
         rd_cnt_ff     <= rd_cnt_in;
         proc_vld_ff   <= proc_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff             <= cmd_in;
      note_ff            <= note_in;
      vel_ff             <= vel_in;
      proc_idx_ff        <= proc_idx_in;
      match_found_ff     <= match_found_in;
      match_idx_ff       <= match_idx_in;
      free_found_ff      <= free_found_in;
      free_idx_ff        <= free_idx_in;
      best_age_ff        <= best_age_in;
      best_idx_ff        <= best_idx_in;
      pend_idx_ff        <= pend_idx_in;
      all_idx_ff         <= all_idx_in;
      rsp_voice_index_ff <= rsp_voice_index_in;
      rsp_action_ff      <= rsp_action_in;
      rsp_pitch_ff       <= rsp_pitch_in;
      rsp_level_ff       <= rsp_level_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_voice_index = rsp_voice_index_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_pitch       = rsp_pitch_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_last        = rsp_last_ff;

   // A trigger is always the only item of its note-on
   `PVA_ASSERT_IMPL(a_trigger_last, clock, reset, rsp_strobe_ff && (rsp_action_ff == ACT_TRIGGER), rsp_last_ff, "trigger without last")
   // The voice just triggered must be marked busy
   `PVA_ASSERT_IMPL(a_trigger_busy, clock, reset, rsp_strobe_ff && (rsp_action_ff == ACT_TRIGGER), busy_ff[rsp_voice_index_ff], "triggered voice not busy")
   // Release items carry no pitch or level
   `PVA_ASSERT_IMPL(a_release_zero, clock, reset, rsp_strobe_ff && (rsp_action_ff == ACT_RELEASE), (rsp_pitch_ff == '0) && (rsp_level_ff == '0), "release with pitch or level")
   // A tick never holds the block busy
   `PVA_ASSERT_NEXT(a_tick_free, clock, reset, accept && (req_command == CMD_TICK), !busy, "tick left block busy")

endmodule
